FILE: rtl/npm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npm_pkg
// Shared types, codes and the preset pose list of the nearest pose matcher.
// ----------------------------------------------------------------------------
package npm_pkg;

   // action codes of a request word
   localparam logic [1:0] ACT_CLASSIFY = 2'd0;
   localparam logic [1:0] ACT_REGISTER = 2'd1;
   localparam logic [1:0] ACT_CLEAR    = 2'd2;

   // status codes of a response word
   localparam logic [2:0] STS_MATCHED  = 3'd0;
   localparam logic [2:0] STS_EMPTY    = 3'd1;
   localparam logic [2:0] STS_UPDATED  = 3'd2;
   localparam logic [2:0] STS_APPENDED = 3'd3;
   localparam logic [2:0] STS_FULL     = 3'd4;
   localparam logic [2:0] STS_CLEARED  = 3'd5;

   // configuration register indexes
   localparam logic CSR_PITCH_LIMIT = 1'b0;
   localparam logic CSR_ROLL_WRAP   = 1'b1;

   localparam logic [6:0]        PITCH_LIMIT_RST = 7'd70;
   localparam logic signed [8:0] ROLL_WRAP_RST   = -9'sd160;
   localparam logic [9:0]        NO_MATCH_DIST   = 10'd999;
   localparam int                PRESET_COUNT    = 12;

   typedef struct packed {
      logic [7:0]        key;
      logic signed [8:0] roll;
      logic signed [7:0] pitch;
   } pose_type;

   function automatic pose_type preset_pose(input logic [3:0] idx);
      pose_type p;
      case (idx)
         4'd0:    p = '{key: 8'h31, roll:    9'sd0, pitch:  8'sd0};
         4'd1:    p = '{key: 8'h32, roll:   9'sd45, pitch:  8'sd0};
         4'd2:    p = '{key: 8'h33, roll:   9'sd90, pitch:  8'sd0};
         4'd3:    p = '{key: 8'h34, roll:  9'sd135, pitch:  8'sd0};
         4'd4:    p = '{key: 8'h35, roll:  9'sd180, pitch:  8'sd0};
         4'd5:    p = '{key: 8'h36, roll:   9'sd90, pitch: -8'sd70};
         4'd6:    p = '{key: 8'h37, roll:   9'sd90, pitch: -8'sd35};
         4'd7:    p = '{key: 8'h38, roll:   9'sd90, pitch:  8'sd35};
         4'd8:    p = '{key: 8'h39, roll:   9'sd90, pitch:  8'sd70};
         4'd9:    p = '{key: 8'h61, roll:  -9'sd45, pitch:  8'sd0};
         4'd10:   p = '{key: 8'h63, roll:  -9'sd90, pitch:  8'sd0};
         4'd11:   p = '{key: 8'h63, roll: -9'sd135, pitch:  8'sd0};
         default: p = '{key: 8'h00, roll:    9'sd0, pitch:  8'sd0};
      endcase
      return p;
   endfunction

endpackage

FILE: rtl/nearest_pose_matcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_pose_matcher_top
// Nearest pose classifier over a small pose table, one entry per cycle.
// ----------------------------------------------------------------------------
// usage
//   req_*  : one word per operation: classify roll/pitch, register a pose
//            under req_pose_key, or clear the table. valid/ready handshake.
//   rsp_*  : one word per request: status, matched key, entry index and
//            distance. valid/ready handshake, held in an output register.
//   csr_*  : write-only port for pitch limit and roll wrap threshold; write
//            only while no request is in flight.
// timing
//   classify walks the table through the shared distance unit and register
//   compares keys, one entry per cycle behind the registered memory read.
//   clear and a classify on an empty table skip the walk. a register that
//   hits a key stops the walk early. one request is worked on at a time.
// reset
//   table holds the twelve preset poses, registers return to 70 and -160.
// stalls
//   a finished word waits in the output register; the next request is taken
//   meanwhile, but its result waits until the output register is free.
// ----------------------------------------------------------------------------
module nearest_pose_matcher_top
   import npm_pkg::*;
#(
   parameter int MAX_POSES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_action,
   input  logic signed [8:0] req_roll,
   input  logic signed [7:0] req_pitch,
   input  logic [7:0]        req_pose_key,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [7:0]        rsp_matched_key,
   output logic [3:0]        rsp_entry_index,
   output logic [9:0]        rsp_distance,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [8:0]        csr_wdata
);

   localparam int AW      = (MAX_POSES > 1) ? $clog2(MAX_POSES) : 1;
   localparam int CW      = $clog2(MAX_POSES + 1);
   localparam int PresetN = (MAX_POSES < PRESET_COUNT) ? MAX_POSES : PRESET_COUNT;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     scan_idx_ff, scan_idx_in;
   logic              eval_vld_ff, eval_vld_in;
   logic [AW-1:0]     eval_idx_ff, eval_idx_in;
   logic              is_reg_ff, is_reg_in;
   logic signed [8:0] roll_ff, roll_in;
   logic signed [7:0] pitch_ff, pitch_in;
   logic [7:0]        key_ff, key_in;
   logic              over_ff, over_in;
   logic              wrap_ff, wrap_in;
   logic [9:0]        best_ff, best_in;
   logic [AW-1:0]     best_idx_ff, best_idx_in;
   logic [7:0]        best_key_ff, best_key_in;
   logic [2:0]        res_status_ff, res_status_in;
   logic [7:0]        res_key_ff, res_key_in;
   logic [3:0]        res_idx_ff, res_idx_in;
   logic [9:0]        res_dist_ff, res_dist_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_key_ff, rsp_key_in;
   logic [3:0]        rsp_idx_ff, rsp_idx_in;
   logic [9:0]        rsp_dist_ff, rsp_dist_in;
   logic [6:0]        pitch_limit_ff, pitch_limit_in;
   logic signed [8:0] roll_wrap_ff, roll_wrap_in;

   logic              accept;
   logic [7:0]        abs_pitch;
   logic              issue;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   pose_type          wr_data;
   logic [AW-1:0]     rd_addr;
   pose_type          rd_pose;
   logic [9:0]        entry_dist;

   npm_table #(
      .MAX_POSES (MAX_POSES),
      .AW        (AW)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_pose)
   );

   npm_dist u_dist (
      .roll       (roll_ff),
      .pitch      (pitch_ff),
      .pitch_over (over_ff),
      .roll_wrap  (wrap_ff),
      .pose       (rd_pose),
      .l1_dist    (entry_dist)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign abs_pitch = req_pitch[7] ? 8'(-req_pitch) : 8'(req_pitch);
   assign issue     = (scan_idx_ff < count_ff);
   assign rd_addr   = scan_idx_ff[AW-1:0];
   assign wr_data   = '{key: key_ff, roll: roll_ff, pitch: pitch_ff};

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      scan_idx_in    = scan_idx_ff;
      eval_vld_in    = 1'b0;
      eval_idx_in    = rd_addr;
      is_reg_in      = is_reg_ff;
      roll_in        = roll_ff;
      pitch_in       = pitch_ff;
      key_in         = key_ff;
      over_in        = over_ff;
      wrap_in        = wrap_ff;
      best_in        = best_ff;
      best_idx_in    = best_idx_ff;
      best_key_in    = best_key_ff;
      res_status_in  = res_status_ff;
      res_key_in     = res_key_ff;
      res_idx_in     = res_idx_ff;
      res_dist_in    = res_dist_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_dist_in    = rsp_dist_ff;
      pitch_limit_in = pitch_limit_ff;
      roll_wrap_in   = roll_wrap_ff;
      wr_en          = 1'b0;
      wr_addr        = count_ff[AW-1:0];

      if (csr_we) begin
         case (csr_index)
            CSR_PITCH_LIMIT: pitch_limit_in = csr_wdata[6:0];
            CSR_ROLL_WRAP:   roll_wrap_in   = $signed(csr_wdata);
            default:         pitch_limit_in = pitch_limit_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               roll_in     = req_roll;
               pitch_in    = req_pitch;
               key_in      = req_pose_key;
               over_in     = abs_pitch > {1'b0, pitch_limit_ff};
               wrap_in     = req_roll < roll_wrap_ff;
               is_reg_in   = (req_action == ACT_REGISTER);
               scan_idx_in = '0;
               best_in     = NO_MATCH_DIST;
               best_idx_in = '0;
               res_key_in  = '0;
               res_idx_in  = '0;
               res_dist_in = '0;
               case (req_action)
                  ACT_CLEAR: begin
                     count_in      = '0;
                     res_status_in = STS_CLEARED;
                     state_in      = S_DONE;
                  end
                  ACT_REGISTER: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     if (count_ff == '0) begin
                        res_status_in = STS_EMPTY;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            // read of entry i is issued in the cycle before its evaluation
            eval_vld_in = issue;
            if (issue) begin
               scan_idx_in = scan_idx_ff + 1'b1;
            end
            if (eval_vld_ff) begin
               if (is_reg_ff) begin
                  if (rd_pose.key == key_ff) begin
                     wr_en         = 1'b1;
                     wr_addr       = eval_idx_ff;
                     res_status_in = STS_UPDATED;
                     res_idx_in    = 4'(eval_idx_ff);
                     eval_vld_in   = 1'b0;
                     state_in      = S_DONE;
                  end
               end else if (entry_dist < best_ff) begin
                  best_in     = entry_dist;
                  best_idx_in = eval_idx_ff;
                  best_key_in = rd_pose.key;
               end
            end else if (!issue) begin
               state_in = S_DONE;
               if (!is_reg_ff) begin
                  res_status_in = STS_MATCHED;
                  res_key_in    = best_key_ff;
                  res_idx_in    = 4'(best_idx_ff);
                  res_dist_in   = best_ff;
               end else if (32'(count_ff) < MAX_POSES) begin
                  wr_en         = 1'b1;
                  count_in      = count_ff + 1'b1;
                  res_status_in = STS_APPENDED;
                  res_idx_in    = 4'(count_ff);
               end else begin
                  res_status_in = STS_FULL;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_key_in    = res_key_ff;
               rsp_idx_in    = res_idx_ff;
               rsp_dist_in   = res_dist_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= CW'(PresetN);
         eval_vld_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pitch_limit_ff <= PITCH_LIMIT_RST;
         roll_wrap_ff   <= ROLL_WRAP_RST;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         eval_vld_ff    <= eval_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
         pitch_limit_ff <= pitch_limit_in;
         roll_wrap_ff   <= roll_wrap_in;
      end
      scan_idx_ff   <= scan_idx_in;
      eval_idx_ff   <= eval_idx_in;
      is_reg_ff     <= is_reg_in;
      roll_ff       <= roll_in;
      pitch_ff      <= pitch_in;
      key_ff        <= key_in;
      over_ff       <= over_in;
      wrap_ff       <= wrap_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      best_key_ff   <= best_key_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_idx_ff    <= res_idx_in;
      res_dist_ff   <= res_dist_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_dist_ff   <= rsp_dist_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_matched_key = rsp_key_ff;
   assign rsp_entry_index = rsp_idx_ff;
   assign rsp_distance    = rsp_dist_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_POSES)
      else $error("pose count above table depth");

   a_eval_in_scan: assert property (@(posedge clock) disable iff (reset)
      eval_vld_ff |-> (state_ff == S_SCAN))
      else $error("entry evaluated outside table walk");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_action == ACT_CLEAR)) |=> (count_ff == '0))
      else $error("clear left entries in the table");

   a_match_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STS_MATCHED)) |-> (rsp_dist_ff < NO_MATCH_DIST))
      else $error("match reported without a scored entry");
`endif

endmodule

FILE: rtl/npm_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npm_table
// Pose memory with one write and one registered read port. Entries of the
// preset range read as their preset until first written.
// ----------------------------------------------------------------------------
module npm_table
   import npm_pkg::*;
#(
   parameter int MAX_POSES = 16,
   parameter int AW        = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  pose_type      wr_data,
   input  logic [AW-1:0] rd_addr,
   output pose_type      rd_data
);

   localparam int PresetN = (MAX_POSES < PRESET_COUNT) ? MAX_POSES : PRESET_COUNT;

   pose_type             mem_ff [MAX_POSES];
   pose_type             rd_mem_ff;
   logic [AW-1:0]        rd_addr_ff;
   logic                 rd_preset_ff;
   logic [MAX_POSES-1:0] written_ff;
   logic                 rd_preset_in;

   assign rd_preset_in = (32'(rd_addr) < PresetN) && !written_ff[rd_addr];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_mem_ff    <= mem_ff[rd_addr];
      rd_addr_ff   <= rd_addr;
      rd_preset_ff <= rd_preset_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr_en) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_preset_ff ? preset_pose(4'(rd_addr_ff)) : rd_mem_ff;

endmodule

FILE: rtl/npm_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npm_dist
// Shared distance unit: roll plus pitch L1 distance of one table entry.
// ----------------------------------------------------------------------------
module npm_dist
   import npm_pkg::*;
(
   input  logic signed [8:0] roll,
   input  logic signed [7:0] pitch,
   input  logic              pitch_over,
   input  logic              roll_wrap,
   input  pose_type          pose,
   output logic [9:0]        l1_dist
);

   logic signed [10:0] roll_x;
   logic signed [10:0] abs_roll_x;
   logic signed [10:0] entry_roll_x;
   logic signed [10:0] droll;
   logic signed [10:0] dwrap;
   logic signed [10:0] dpitch;
   logic [9:0]         rd_plain;
   logic [9:0]         rd_wrap;
   logic [9:0]         rd;
   logic [9:0]         pd;

   always_comb begin
      roll_x       = 11'(roll);
      entry_roll_x = 11'($signed(pose.roll));
      abs_roll_x   = roll_x[10] ? -roll_x : roll_x;
      droll        = roll_x - entry_roll_x;
      dwrap        = abs_roll_x - entry_roll_x;
      dpitch       = 11'(pitch) - 11'($signed(pose.pitch));
      rd_plain     = droll[10] ? 10'(-droll) : 10'(droll);
      rd_wrap      = dwrap[10] ? 10'(-dwrap) : 10'(dwrap);
      pd           = dpitch[10] ? 10'(-dpitch) : 10'(dpitch);
      if (pitch_over) begin
         rd = '0;
      end else if (roll_wrap && (rd_wrap < rd_plain)) begin
         rd = rd_wrap;
      end else begin
         rd = rd_plain;
      end
      // sum stays below 767, no carry out
      l1_dist = rd + pd;
   end

endmodule
